[hdl/hsv2rgb_pkg.sv]
// hsv2rgb_pkg: constants and types for the hsv to rgb pixel converter
// no dependencies; imported by hsv_to_rgb_converter and hsv_to_rgb_converter_tb

package hsv2rgb_pkg;

    localparam int HUE_W      = 24;
    localparam int UNIT_W     = 12;
    localparam int CH_W       = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // hue wrap: hue = 128*a + low7, turn = 45*128
    localparam int          HUE_LOW_W  = 7;
    localparam int          HUE_TURN   = 5760;
    localparam int          HUE_SECTOR = 960;
    localparam int          HUE_SPAN   = 1920;
    localparam logic [17:0] WRAP_BIAS  = 18'd65565;
    localparam logic [18:0] RECIP_45   = 19'd372828;
    localparam logic [5:0]  TURN_HI    = 6'd45;

    localparam logic [8:0]  UNIT_ONE   = 9'd256;

    // channel sum bound: 65536 * 960
    localparam logic [25:0] SUM_MAX    = 26'd62914560;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

endpackage

[hdl/hsv_to_rgb_converter.sv]
// hsv_to_rgb_converter: six-stage pipelined hsv to 8-bit rgb pixel converter
// each item is registered through stages 1 to 6 in order, and stage 6 drives the output
// throughput: one item per cycle, each stage stalls only when the next one is full
// hue wrap uses a reciprocal multiply by 1/45, chroma a 9x9 multiply, scaled chroma and x two 17x10 multipliers
// reset: rst_n clears all stage valid bits, payload registers are not reset
// depends on hsv2rgb_pkg

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hue[23:0], saturation[35:24], brightness[47:36]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [6:1] vld_reg;
    logic [6:1] load;

    // stage 1
    logic [17:0] u1_reg, u1_next;
    logic [6:0]  lo1_reg;
    logic [8:0]  s1_reg, s1_next;
    logic [8:0]  v1_reg, v1_next;
    // stage 2
    logic [17:0] u2_reg;
    logic [11:0] q2_reg, q2_next;
    logic [6:0]  lo2_reg;
    logic [8:0]  s2_reg;
    logic [8:0]  v2_reg;
    logic [36:0] prod2;
    // stage 3
    logic [12:0] h3_reg, h3_next;
    logic [16:0] c3_reg, c3_next;
    logic [8:0]  v3_reg;
    logic [17:0] rem3;
    // stage 4
    sector_t     sec4_reg, sec4_next;
    logic [9:0]  t4_reg, t4_next;
    logic [16:0] c4_reg;
    logic [8:0]  v4_reg;
    logic [12:0] base4;
    logic [12:0] f4;
    // stage 5
    sector_t     sec5_reg;
    logic [25:0] cc5_reg, cc5_next;
    logic [25:0] xx5_reg, xx5_next;
    logic [25:0] mm5_reg, mm5_next;
    logic [26:0] cc5_full;
    logic [26:0] xx5_full;
    logic [26:0] vv5_full;
    // stage 6
    logic [25:0] r6_sum, g6_sum, b6_sum;
    logic [25:0] r6_sum_reg, g6_sum_reg, b6_sum_reg;
    logic [25:0] r6_sel, g6_sel, b6_sel;
    logic [30:0] r6_scl, g6_scl, b6_scl;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;
    logic [CH_W-1:0] red_next, green_next, blue_next;

    // ready chain from the output back to the input
    always_comb
    begin
        load[6] = !vld_reg[6] || m_axis_tready;
        for (int k = 5; k >= 1; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    assign s_axis_tready = load[1];
    assign m_axis_tvalid = vld_reg[6];
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[1])
            begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (load[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: hue split and bias, clamp of saturation and value
    always_comb
    begin
        logic [11:0] sat;
        logic [11:0] bri;
        sat = s_axis_tdata[35:24];
        bri = s_axis_tdata[47:36];
        u1_next = {s_axis_tdata[HUE_W-1], s_axis_tdata[HUE_W-1:HUE_LOW_W]} + WRAP_BIAS;
        if (sat[UNIT_W-1])
        begin
            s1_next = '0;
        end
        else if (sat[10:0] > 11'(UNIT_ONE))
        begin
            s1_next = UNIT_ONE;
        end
        else
        begin
            s1_next = sat[8:0];
        end
        if (bri[UNIT_W-1])
        begin
            v1_next = '0;
        end
        else if (bri[10:0] > 11'(UNIT_ONE))
        begin
            v1_next = UNIT_ONE;
        end
        else
        begin
            v1_next = bri[8:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            u1_reg  <= u1_next;
            lo1_reg <= s_axis_tdata[HUE_LOW_W-1:0];
            s1_reg  <= s1_next;
            v1_reg  <= v1_next;
        end
    end

    // stage 2: quotient by 45 through the reciprocal
    assign prod2   = 37'(u1_reg) * 37'(RECIP_45);
    assign q2_next = prod2[35:24];

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            u2_reg  <= u1_reg;
            q2_reg  <= q2_next;
            lo2_reg <= lo1_reg;
            s2_reg  <= s1_reg;
            v2_reg  <= v1_reg;
        end
    end

    // stage 3: wrapped hue and chroma
    assign rem3    = u2_reg - 18'(q2_reg) * 18'(TURN_HI);
    assign h3_next = {rem3[5:0], lo2_reg};
    assign c3_next = 17'(s2_reg) * 17'(v2_reg);

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            h3_reg <= h3_next;
            c3_reg <= c3_next;
            v3_reg <= v2_reg;
        end
    end

    // stage 4: sector and x weight
    always_comb
    begin
        if (h3_reg < 13'(HUE_SECTOR))
        begin
            sec4_next = SEC_RED_YEL;
        end
        else if (h3_reg < 13'(2 * HUE_SECTOR))
        begin
            sec4_next = SEC_YEL_GRN;
        end
        else if (h3_reg < 13'(3 * HUE_SECTOR))
        begin
            sec4_next = SEC_GRN_CYN;
        end
        else if (h3_reg < 13'(4 * HUE_SECTOR))
        begin
            sec4_next = SEC_CYN_BLU;
        end
        else if (h3_reg < 13'(5 * HUE_SECTOR))
        begin
            sec4_next = SEC_BLU_MAG;
        end
        else
        begin
            sec4_next = SEC_MAG_RED;
        end

        case (sec4_next)
            SEC_RED_YEL, SEC_YEL_GRN: base4 = '0;
            SEC_GRN_CYN, SEC_CYN_BLU: base4 = 13'(HUE_SPAN);
            default:                  base4 = 13'(2 * HUE_SPAN);
        endcase

        f4 = h3_reg - base4;
        if (f4 >= 13'(HUE_SECTOR))
        begin
            t4_next = 10'(13'(HUE_SPAN) - f4);
        end
        else
        begin
            t4_next = f4[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            sec4_reg <= sec4_next;
            t4_reg   <= t4_next;
            c4_reg   <= c3_reg;
            v4_reg   <= v3_reg;
        end
    end

    // stage 5: scaled chroma, x and offset
    assign cc5_full = 27'(c4_reg) * 27'(HUE_SECTOR);
    assign xx5_full = 27'(c4_reg) * 27'(t4_reg);
    assign vv5_full = {27'(v4_reg) * 27'(HUE_SECTOR)} << 8;
    assign cc5_next = cc5_full[25:0];
    assign xx5_next = xx5_full[25:0];
    assign mm5_next = 26'(vv5_full - cc5_full);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            sec5_reg <= sec4_reg;
            cc5_reg  <= cc5_next;
            xx5_reg  <= xx5_next;
            mm5_reg  <= mm5_next;
        end
    end

    // stage 6: channel select, offset and scale by 255/(65536*960) = 17/2^22
    always_comb
    begin
        case (sec5_reg)
            SEC_RED_YEL:
            begin
                r6_sel = cc5_reg; g6_sel = xx5_reg; b6_sel = '0;
            end
            SEC_YEL_GRN:
            begin
                r6_sel = xx5_reg; g6_sel = cc5_reg; b6_sel = '0;
            end
            SEC_GRN_CYN:
            begin
                r6_sel = '0; g6_sel = cc5_reg; b6_sel = xx5_reg;
            end
            SEC_CYN_BLU:
            begin
                r6_sel = '0; g6_sel = xx5_reg; b6_sel = cc5_reg;
            end
            SEC_BLU_MAG:
            begin
                r6_sel = xx5_reg; g6_sel = '0; b6_sel = cc5_reg;
            end
            default:
            begin
                r6_sel = cc5_reg; g6_sel = '0; b6_sel = xx5_reg;
            end
        endcase
        r6_sum     = r6_sel + mm5_reg;
        g6_sum     = g6_sel + mm5_reg;
        b6_sum     = b6_sel + mm5_reg;
        r6_scl     = {1'b0, r6_sum, 4'b0} + 31'(r6_sum);
        g6_scl     = {1'b0, g6_sum, 4'b0} + 31'(g6_sum);
        b6_scl     = {1'b0, b6_sum, 4'b0} + 31'(b6_sum);
        red_next   = r6_scl[29:22];
        green_next = g6_scl[29:22];
        blue_next  = b6_scl[29:22];
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            r6_sum_reg <= r6_sum;
            g6_sum_reg <= g6_sum;
            b6_sum_reg <= b6_sum;
        end
    end

    // an empty output stage leaves every stage free to advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (h3_reg < 13'(HUE_TURN)))
        else $error("wrapped hue out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (t4_reg <= 10'(HUE_SECTOR)) && (c4_reg <= {v4_reg, 8'b0}))
        else $error("x weight or chroma out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> (r6_sum_reg <= SUM_MAX) && (g6_sum_reg <= SUM_MAX)
                       && (b6_sum_reg <= SUM_MAX))
        else $error("channel sum exceeds full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[6] && !m_axis_tready) |=> (m_axis_tdata == $past(m_axis_tdata)))
        else $error("stalled output item changed");

endmodule

[bench/hsv_to_rgb_converter_tb.sv]
// hsv_to_rgb_converter_tb: self-checking bench for the hsv to rgb pixel converter
// streams directed and random hsv pixels with random gaps and output stalls, predicts rgb per item
// depends on hsv2rgb_pkg and hsv_to_rgb_converter

module hsv_to_rgb_converter_tb
    import hsv2rgb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_ITEMS = 424;
    localparam int     PIPE_LATENCY = 5;
    localparam int     HOLD_CYCLES  = 60;
    localparam int     DRAIN_LIMIT  = 5000;
    localparam longint TURN_16THS   = 5760;
    localparam longint SECTOR_16THS = 960;
    localparam longint SPAN_16THS   = 1920;
    localparam longint UNIT_FULL    = 256;
    localparam longint CHANNEL_DIV  = 65536 * 960;

    // brightness, saturation, hue from the top bit down
    typedef struct packed {
        logic [UNIT_W-1:0] brightness;
        logic [UNIT_W-1:0] saturation;
        logic [HUE_W-1:0]  hue;
    } hsv_item_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    class rgb_scoreboard;
        rgb_t expected_rgb[$];
        int   mismatches;
        int   pixels_seen;
        int   results_seen;

        function longint clamp_unit(longint raw);
            if (raw < 0)
                return 0;
            if (raw > UNIT_FULL)
                return UNIT_FULL;
            return raw;
        endfunction

        function logic [CH_W-1:0] scale_channel(longint sum);
            longint scaled;
            scaled = (sum * 255) / CHANNEL_DIV;
            return scaled[CH_W-1:0];
        endfunction

        function rgb_t predict_rgb(hsv_item_t px);
            longint  hue_w;
            longint  sat;
            longint  val;
            longint  chroma;
            longint  hue_dev;
            longint  c_term;
            longint  x_term;
            longint  m_term;
            longint  r_part;
            longint  g_part;
            longint  b_part;
            sector_t sec;
            rgb_t    res;
            hue_w = $signed(px.hue);
            hue_w = hue_w % TURN_16THS;
            if (hue_w < 0)
                hue_w = hue_w + TURN_16THS;
            sat = $signed(px.saturation);
            val = $signed(px.brightness);
            sat = clamp_unit(sat);
            val = clamp_unit(val);
            chroma = sat * val;
            hue_dev = (hue_w % SPAN_16THS) - SECTOR_16THS;
            if (hue_dev < 0)
                hue_dev = -hue_dev;
            c_term = chroma * SECTOR_16THS;
            x_term = chroma * (SECTOR_16THS - hue_dev);
            m_term = val * UNIT_FULL * SECTOR_16THS - c_term;
            sec = sector_t'(hue_w / SECTOR_16THS);
            case (sec)
                SEC_RED_YEL:
                begin
                    r_part = c_term; g_part = x_term; b_part = 0;
                end
                SEC_YEL_GRN:
                begin
                    r_part = x_term; g_part = c_term; b_part = 0;
                end
                SEC_GRN_CYN:
                begin
                    r_part = 0; g_part = c_term; b_part = x_term;
                end
                SEC_CYN_BLU:
                begin
                    r_part = 0; g_part = x_term; b_part = c_term;
                end
                SEC_BLU_MAG:
                begin
                    r_part = x_term; g_part = 0; b_part = c_term;
                end
                default:
                begin
                    r_part = c_term; g_part = 0; b_part = x_term;
                end
            endcase
            res.red   = scale_channel(r_part + m_term);
            res.green = scale_channel(g_part + m_term);
            res.blue  = scale_channel(b_part + m_term);
            return res;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void note_pixel(hsv_item_t px);
            pixels_seen++;
            expected_rgb.push_back(predict_rgb(px));
        endfunction

        function void check_rgb(rgb_t got);
            rgb_t exp_rgb;
            results_seen++;
            if (expected_rgb.size() == 0)
            begin
                flag($sformatf("unexpected result r=%0d g=%0d b=%0d",
                    got.red, got.green, got.blue));
                return;
            end
            exp_rgb = expected_rgb.pop_front();
            if (got.red !== exp_rgb.red || got.green !== exp_rgb.green
                || got.blue !== exp_rgb.blue)
                flag($sformatf("result %0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                    results_seen, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                    got.red, got.green, got.blue));
        endfunction

        function void close_out();
            if (expected_rgb.size() != 0)
                flag($sformatf("%0d expected results never arrived", expected_rgb.size()));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bit            hold_output = 1'b0;
    rgb_scoreboard sb = new();

    hsv_to_rgb_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(hsv_item_t'(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_rgb(rgb_t'(m_axis_tdata));
    end

    function automatic hsv_item_t make_pixel(int h, int s, int v);
        hsv_item_t px;
        px.hue        = h[HUE_W-1:0];
        px.saturation = s[UNIT_W-1:0];
        px.brightness = v[UNIT_W-1:0];
        return px;
    endfunction

    function automatic int random_unit();
        int pick;
        int raw;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom_range(0, 256);
        if (pick < 7)
        begin
            raw = $urandom;
            return raw;
        end
        case ($urandom_range(0, 8))
            0: return 0;
            1: return 1;
            2: return 128;
            3: return 255;
            4: return 256;
            5: return 257;
            6: return -1;
            7: return -2048;
            default: return 2047;
        endcase
    endfunction

    function automatic hsv_item_t random_pixel();
        int pick;
        int h;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            h = $urandom_range(0, 5759);
        else if (pick < 6)
            h = $urandom;
        else if (pick < 8)
        begin
            h = $urandom_range(0, 6) * 960;
            h = h + int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1))
                h = h - 5760;
        end
        else
            h = -int'($urandom_range(1, 20000));
        return make_pixel(h, random_unit(), random_unit());
    endfunction

    task automatic send_pixel(input hsv_item_t px);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_pixel(make_pixel(0, 256, 256));
        send_pixel(make_pixel(960, 256, 256));
        send_pixel(make_pixel(1920, 256, 256));
        send_pixel(make_pixel(2880, 256, 256));
        send_pixel(make_pixel(3840, 256, 256));
        send_pixel(make_pixel(4800, 256, 256));
        send_pixel(make_pixel(5759, 256, 256));
        send_pixel(make_pixel(5760, 256, 256));
        send_pixel(make_pixel(-1, 256, 256));
        send_pixel(make_pixel(-5760, 256, 256));
        send_pixel(make_pixel(-8388608, 256, 256));
        send_pixel(make_pixel(8388607, 256, 256));
        send_pixel(make_pixel(480, 256, 256));
        send_pixel(make_pixel(1440, 128, 200));
        send_pixel(make_pixel(2000, 0, 200));
        send_pixel(make_pixel(3000, 0, 256));
        send_pixel(make_pixel(100, -2048, 2047));
        send_pixel(make_pixel(4000, 2047, -2048));
        send_pixel(make_pixel(4500, 257, 255));
        send_pixel(make_pixel(5000, -1, 256));
        send_pixel(make_pixel(700, 255, 1));
        send_pixel(make_pixel(1234, 256, 0));
        send_pixel(make_pixel(-2000, 200, 180));
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(-8388608, -2048, -2048));
        send_pixel(make_pixel(8388607, 2047, 2047));
    endtask

    task automatic run_random();
        int sent;
        int burst;
        int i;
        bit pressed;
        sent = 0;
        pressed = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!pressed && sent >= RANDOM_ITEMS / 2)
            begin
                pressed = 1'b1;
                wait_drained();
                hold_output = 1'b1;
                for (i = 0; i < 40; i++)
                    send_pixel(random_pixel());
                sent = sent + 40;
                wait_drained();
            end
            burst = $urandom_range(1, 24);
            for (i = 0; i < burst; i++)
                send_pixel(random_pixel());
            sent = sent + burst;
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    // output side stall pattern, with one long hold-off on request
    initial
    begin : receiver
        int mode;
        int stretch;
        int period;
        int i;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 80);
            period  = $urandom_range(2, 5);
            for (i = 0; i < stretch && !hold_output; i++)
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (i % period == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : sender
        int waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random();
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.expected_rgb.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        sb.close_out();
        $display("converted %0d hsv pixels into %0d rgb results, %0d mismatches",
            sb.pixels_seen, sb.results_seen, sb.mismatches);
        $display("covered hue wraps, sector edges, clamped inputs and a long output stall");
        if (sb.mismatches == 0)
            $display("hsv_to_rgb_converter regression: pass");
        else
            $display("hsv_to_rgb_converter regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #400000;
        $display("timeout with %0d results outstanding", sb.expected_rgb.size());
        $display("hsv_to_rgb_converter regression: fail");
        $finish;
    end

endmodule
